// File: hw/rtl/dnsqe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsqe_pkg
// shared constants, register indexes and controller/datapath interface types
// for the dns query message encoder
// ----------------------------------------------------------------------------
package dnsqe_pkg;

   // default label limit, legal range 1 to 63
   localparam int unsigned MAX_LABEL_DEF = 32;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_ID     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_FLAGS = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_TYPE   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_CLASS  = CSR_IDX_W'(3);

   localparam logic [15:0] QUERY_ID_RST     = 16'h1234;
   localparam logic [15:0] HEADER_FLAGS_RST = 16'h0100;
   localparam logic [15:0] QUERY_TYPE_RST   = 16'h0001;
   localparam logic [15:0] QUERY_CLASS_RST  = 16'h0001;

   // label separator
   localparam logic [7:0] DOT_CHAR = 8'd46;

   // byte counter for header and trailer runs
   localparam int unsigned CNT_W = 4;
   localparam logic [CNT_W-1:0] HDR_LAST  = CNT_W'(11);
   localparam logic [CNT_W-1:0] TAIL_LAST = CNT_W'(4);

   // source of the next output byte
   typedef enum logic [1:0] {
      SRC_HDR  = 2'd0,
      SRC_LEN  = 2'd1,
      SRC_DATA = 2'd2,
      SRC_TAIL = 2'd3
   } src_sel_type;

   typedef struct packed {
      logic        accept;   // take the item on the request port
      logic        emit;     // load one byte into the output register
      src_sel_type src;
      logic        run_end;
      logic        msg_end;
   } dp_cmd_type;

   typedef struct packed {
      logic acc_hdr;    // item at the port opens a message
      logic acc_flush;  // item at the port flushes a non-empty label
      logic acc_fin;    // item at the port ends the message
      logic flush;      // latched flush of the item at work
      logic fin;        // latched end of the item at work
      logic out_free;   // output register can take a byte
      logic hdr_last;
      logic data_last;
      logic tail_last;
   } dp_sts_type;

endpackage

// File: hw/rtl/dns_query_message_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_message_encoder
// builds a dns query message byte stream from a dotted hostname
// ----------------------------------------------------------------------------
// A hostname enters one character per item and leaves as a DNS query message,
// one byte per result item. The first item of a message first sends the
// 12-byte header (query id, flags, question count of one, three zero counts).
// Characters collect in a label buffer of MAX_LABEL bytes; a dot or the final
// character replays the label as a length byte plus the label bytes, and
// empty labels send nothing. The final character then adds the root zero,
// query type and query class. Characters past MAX_LABEL in one label are
// dropped and rsp_label_cut stays high for the rest of that message.
// Flow: one item is taken while the sequencer is idle, and then its bytes go
// out one per clock, unless rsp_stall holds them, through a single output
// register: 12 header bytes (first item only), 1 + L bytes for a label flush
// and 5 trailer bytes (final item); an item that only buffers a character
// sends no bytes. The label buffer has a single read port. A new item is not
// taken until the last byte of the item at work is loaded. The csr port
// is always ready and is meant to be written while the block is idle.
module dns_query_message_encoder
   import dnsqe_pkg::*;
#(
   parameter int unsigned MAX_LABEL = MAX_LABEL_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // character items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_host_char,
   input  logic                  req_final_char,
   // message byte items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_run_end,
   output logic                  rsp_message_end,
   output logic                  rsp_label_cut,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // writes are always taken and land in the next cycle
   assign csr_ready = 1'b1;

   // sequencer: picks the run (header, length, label, trailer) and paces bytes
   dnsqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // label buffer, message state, csr registers and output register
   dnsqe_dpath #(
      .MAX_LABEL (MAX_LABEL)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_host_char   (req_host_char),
      .req_final_char  (req_final_char),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_end     (rsp_run_end),
      .rsp_message_end (rsp_message_end),
      .rsp_label_cut   (rsp_label_cut)
   );

endmodule

// File: hw/rtl/dnsqe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsqe_ctrl
// sequencer that walks header, length, label and trailer runs of one item
// ----------------------------------------------------------------------------
module dnsqe_ctrl
   import dnsqe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_HDR  = 5'b00010,
      S_LEN  = 5'b00100,
      S_DATA = 5'b01000,
      S_TAIL = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.src     = SRC_HDR;
      req_stall   = (state_ff != S_IDLE);
      cmd.accept  = (state_ff == S_IDLE) && req_valid;
      case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               if (sts.acc_hdr) begin
                  state_in = S_HDR;
               end else if (sts.acc_flush) begin
                  state_in = S_LEN;
               end else if (sts.acc_fin) begin
                  state_in = S_TAIL;
               end
            end
         end
         S_HDR: begin
            cmd.emit    = sts.out_free;
            cmd.src     = SRC_HDR;
            cmd.run_end = sts.hdr_last && !sts.flush && !sts.fin;
            if (cmd.emit && sts.hdr_last) begin
               if (sts.flush) begin
                  state_in = S_LEN;
               end else if (sts.fin) begin
                  state_in = S_TAIL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_LEN: begin
            cmd.emit = sts.out_free;
            cmd.src  = SRC_LEN;
            if (cmd.emit) begin
               state_in = S_DATA;
            end
         end
         S_DATA: begin
            cmd.emit    = sts.out_free;
            cmd.src     = SRC_DATA;
            cmd.run_end = sts.data_last && !sts.fin;
            if (cmd.emit && sts.data_last) begin
               state_in = sts.fin ? S_TAIL : S_IDLE;
            end
         end
         S_TAIL: begin
            cmd.emit    = sts.out_free;
            cmd.src     = SRC_TAIL;
            cmd.run_end = sts.tail_last;
            cmd.msg_end = sts.tail_last;
            if (cmd.emit && sts.tail_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // a byte is only loaded when the output register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("byte loaded into a full output register");

   // the last message byte also closes the item's run
   a_msg_end_run: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.msg_end) |-> cmd.run_end)
      else $error("message end without run end");

   // after the last message byte the sequencer is back to idle
   a_msg_end_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.msg_end) |=> (state_ff == S_IDLE))
      else $error("sequencer not idle after message end");

   // label replay only happens for an item that flushes
   a_data_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DATA || state_ff == S_LEN) |-> sts.flush)
      else $error("label replay without flush");
`endif

endmodule

// File: hw/rtl/dnsqe_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsqe_dpath
// label buffer, message state, configuration registers and output register
// ----------------------------------------------------------------------------
module dnsqe_dpath
   import dnsqe_pkg::*;
#(
   parameter int unsigned MAX_LABEL = MAX_LABEL_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_host_char,
   input  logic                  req_final_char,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_run_end,
   output logic                  rsp_message_end,
   output logic                  rsp_label_cut
);

   localparam int unsigned FILL_W = $clog2(MAX_LABEL + 1);
   localparam int unsigned IDX_W  = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_LABEL);

   // configuration
   logic [15:0] query_id_ff;
   logic [15:0] header_flags_ff;
   logic [15:0] query_type_ff;
   logic [15:0] query_class_ff;

   // label buffer
   logic [7:0]        label_mem [MAX_LABEL];
   logic [7:0]        rd_data_ff;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;

   // message and item state
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              hdr_sent_ff;
   logic              hdr_sent_in;
   logic              cut_ff;
   logic              cut_in;
   logic              flush_ff;
   logic              fin_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  idx_in;

   // output register
   logic              rsp_valid_ff;
   logic [7:0]        out_byte_ff;
   logic              run_end_ff;
   logic              msg_end_ff;
   logic              cut_out_ff;

   logic              is_dot;
   logic              room;
   logic              store_en;
   logic [FILL_W-1:0] fill_acc;
   logic [FILL_W-1:0] idx_nxt;
   logic [7:0]        hdr_byte;
   logic [7:0]        tail_byte;
   logic [7:0]        byte_mux;

   assign is_dot   = (req_host_char == DOT_CHAR);
   assign room     = (fill_ff != FILL_MAX);
   assign store_en = !is_dot && room;
   assign fill_acc = store_en ? (fill_ff + FILL_W'(1)) : fill_ff;
   assign idx_nxt  = FILL_W'(idx_ff) + FILL_W'(1);

   always_comb begin
      sts           = '0;
      sts.acc_hdr   = !hdr_sent_ff;
      sts.acc_flush = (is_dot || req_final_char) && (fill_acc != '0);
      sts.acc_fin   = req_final_char;
      sts.flush     = flush_ff;
      sts.fin       = fin_ff;
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
      sts.hdr_last  = (cnt_ff == HDR_LAST);
      sts.tail_last = (cnt_ff == TAIL_LAST);
      sts.data_last = (idx_nxt == fill_ff);
   end

   // header: id, flags, qdcount of one, three zero counts
   always_comb begin
      case (cnt_ff)
         CNT_W'(0): hdr_byte = query_id_ff[15:8];
         CNT_W'(1): hdr_byte = query_id_ff[7:0];
         CNT_W'(2): hdr_byte = header_flags_ff[15:8];
         CNT_W'(3): hdr_byte = header_flags_ff[7:0];
         CNT_W'(5): hdr_byte = 8'd1;
         default:   hdr_byte = 8'd0;
      endcase
   end

   // trailer: root terminator, type, class
   always_comb begin
      case (cnt_ff)
         CNT_W'(1): tail_byte = query_type_ff[15:8];
         CNT_W'(2): tail_byte = query_type_ff[7:0];
         CNT_W'(3): tail_byte = query_class_ff[15:8];
         CNT_W'(4): tail_byte = query_class_ff[7:0];
         default:   tail_byte = 8'd0;
      endcase
   end

   always_comb begin
      case (cmd.src)
         SRC_HDR:  byte_mux = hdr_byte;
         SRC_LEN:  byte_mux = 8'(fill_ff);
         SRC_DATA: byte_mux = rd_data_ff;
         SRC_TAIL: byte_mux = tail_byte;
         default:  byte_mux = 8'd0;
      endcase
   end

   // counters and label read port
   always_comb begin
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      rd_en   = 1'b0;
      rd_addr = '0;
      if (cmd.accept) begin
         cnt_in = '0;
      end else if (cmd.emit) begin
         case (cmd.src)
            SRC_HDR: begin
               cnt_in = sts.hdr_last ? '0 : (cnt_ff + CNT_W'(1));
            end
            SRC_TAIL: begin
               cnt_in = sts.tail_last ? '0 : (cnt_ff + CNT_W'(1));
            end
            SRC_LEN: begin
               idx_in  = '0;
               rd_en   = 1'b1;
               rd_addr = '0;
            end
            SRC_DATA: begin
               idx_in  = idx_nxt[IDX_W-1:0];
               rd_en   = !sts.data_last;
               rd_addr = idx_nxt[IDX_W-1:0];
            end
            default: begin
               cnt_in = '0;
            end
         endcase
      end
   end

   // message state
   always_comb begin
      fill_in     = fill_ff;
      hdr_sent_in = hdr_sent_ff;
      cut_in      = cut_ff;
      if (cmd.accept) begin
         fill_in     = fill_acc;
         hdr_sent_in = 1'b1;
         cut_in      = cut_ff || (!is_dot && !room);
      end else if (cmd.emit) begin
         if (cmd.src == SRC_DATA && sts.data_last) begin
            fill_in = '0;
         end
         if (cmd.msg_end) begin
            fill_in     = '0;
            hdr_sent_in = 1'b0;
            cut_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         hdr_sent_ff <= 1'b0;
         cut_ff      <= 1'b0;
         flush_ff    <= 1'b0;
         fin_ff      <= 1'b0;
         cnt_ff      <= '0;
         idx_ff      <= '0;
      end else begin
         fill_ff     <= fill_in;
         hdr_sent_ff <= hdr_sent_in;
         cut_ff      <= cut_in;
         cnt_ff      <= cnt_in;
         idx_ff      <= idx_in;
         if (cmd.accept) begin
            flush_ff <= sts.acc_flush;
            fin_ff   <= req_final_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && store_en) begin
         label_mem[fill_ff[IDX_W-1:0]] <= req_host_char;
      end
      if (rd_en) begin
         rd_data_ff <= label_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_id_ff     <= QUERY_ID_RST;
         header_flags_ff <= HEADER_FLAGS_RST;
         query_type_ff   <= QUERY_TYPE_RST;
         query_class_ff  <= QUERY_CLASS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_QUERY_ID:     query_id_ff     <= csr_data;
            CSR_HEADER_FLAGS: header_flags_ff <= csr_data;
            CSR_QUERY_TYPE:   query_type_ff   <= csr_data;
            CSR_QUERY_CLASS:  query_class_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_byte_ff <= byte_mux;
         run_end_ff  <= cmd.run_end;
         msg_end_ff  <= cmd.msg_end;
         cut_out_ff  <= cut_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_run_end     = run_end_ff;
   assign rsp_message_end = msg_end_ff;
   assign rsp_label_cut   = cut_out_ff;

endmodule
